@@ sv/b58dec_pkg.sv @@
// b58dec_pkg: types, constants and helper functions shared by the did:key base58 decoder.
// No dependencies; the front end, queue, back end and top level of the decoder import it.
package b58dec_pkg;

   // Defaults for the top-level parameters
   localparam int DIGIT_DEPTH_DEF = 64;
   localparam int KEY_BYTES_DEF   = 32;

   // Fixed-prefix and decoding constants
   localparam int         PREFIX_LEN   = 9;
   localparam logic [6:0] ONES_MAX     = 7'd127;
   localparam logic [7:0] B58_RADIX    = 8'd58;
   localparam logic [7:0] MULTICODEC_0 = 8'hed;
   localparam logic [7:0] MULTICODEC_1 = 8'h01;
   localparam logic [7:0] CHAR_ONE     = 8'h31;

   // Command queue between front and back
   localparam int CMDQ_DEPTH = 4;

   // Result status codes
   typedef enum logic [1:0] {
      STATUS_OK     = 2'd0,
      STATUS_FORMAT = 2'd1,
      STATUS_DECODE = 2'd2,
      STATUS_SIZE   = 2'd3
   } status_type;

   // What the back end does with one character
   typedef enum logic [1:0] {
      CMD_SKIP  = 2'd0,
      CMD_ONE   = 2'd1,
      CMD_DIGIT = 2'd2,
      CMD_ERR   = 2'd3
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [5:0]   value;    // base58 digit value for CMD_DIGIT
      status_type   err;      // error code for CMD_ERR
      logic         last;     // final character of the string
      logic         short_str; // string ended inside the prefix
   } cmd_type;

   // Back-end sequencer states
   typedef enum logic [3:0] {
      BK_IDLE,
      BK_PASS,
      BK_FIN,
      BK_CHK1,
      BK_CHK2,
      BK_ERR_OUT,
      BK_OUT_RD,
      BK_OUT_LD
   } bk_state_type;

   // Expected character at each prefix position ("did:key:z")
   function automatic logic [7:0] prefix_char(input logic [3:0] pos);
      logic [7:0] ch;
      unique case (pos)
         4'd0:    ch = 8'h64; // d
         4'd1:    ch = 8'h69; // i
         4'd2:    ch = 8'h64; // d
         4'd3:    ch = 8'h3a; // :
         4'd4:    ch = 8'h6b; // k
         4'd5:    ch = 8'h65; // e
         4'd6:    ch = 8'h79; // y
         4'd7:    ch = 8'h3a; // :
         4'd8:    ch = 8'h7a; // z
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

   // Base58btc alphabet lookup: {valid, value}
   function automatic logic [6:0] b58_lookup(input logic [7:0] c);
      logic [7:0] v;
      logic       ok;
      ok = 1'b1;
      v  = 8'd0;
      if (c >= 8'h31 && c <= 8'h39) begin        // '1'..'9'
         v = c - 8'h31;
      end else if (c >= 8'h41 && c <= 8'h48) begin // 'A'..'H'
         v = c - 8'h41 + 8'd9;
      end else if (c >= 8'h4a && c <= 8'h4e) begin // 'J'..'N'
         v = c - 8'h4a + 8'd17;
      end else if (c >= 8'h50 && c <= 8'h5a) begin // 'P'..'Z'
         v = c - 8'h50 + 8'd22;
      end else if (c >= 8'h61 && c <= 8'h6b) begin // 'a'..'k'
         v = c - 8'h61 + 8'd33;
      end else if (c >= 8'h6d && c <= 8'h7a) begin // 'm'..'z'
         v = c - 8'h6d + 8'd44;
      end else begin
         ok = 1'b0;
      end
      return {ok, v[5:0]};
   endfunction

endpackage

@@ sv/b58dec_ram.sv @@
// b58dec_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module b58dec_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/b58dec_fifo.sv @@
// b58dec_fifo: short command queue between the character front end and the back end.
// Depends on b58dec_pkg (cmd_type, CMDQ_DEPTH).
module b58dec_fifo (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  b58dec_pkg::cmd_type push_cmd,
   output logic                full,
   input  logic                pop,
   output b58dec_pkg::cmd_type pop_cmd,
   output logic                empty
);
   import b58dec_pkg::*;

   localparam int PW = $clog2(CMDQ_DEPTH);
   localparam int CW = $clog2(CMDQ_DEPTH + 1);

   cmd_type         slot_ff [CMDQ_DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   fill_ff, fill_in;
   logic            do_push, do_pop;

   assign full    = (fill_ff == CW'(CMDQ_DEPTH));
   assign empty   = (fill_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign pop_cmd = slot_ff[rd_ptr_ff];

   // pointer and fill update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

@@ sv/b58dec_front.sv @@
// b58dec_front: accepts characters, checks the did:key:z prefix and classifies the rest
// into commands for the back end. Depends on b58dec_pkg.
module b58dec_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [7:0]          req_tdata,  // [7:0] char_code
   input  logic                req_tlast,  // is_final
   output logic                cmd_push,
   output b58dec_pkg::cmd_type cmd,
   input  logic                cmd_full
);
   import b58dec_pkg::*;

   logic [3:0] pos_ff, pos_in;
   logic       run_ff, run_in;   // inside the leading '1' run
   logic       ferr_ff, ferr_in; // front end already flagged an error
   logic [6:0] lookup;
   logic       in_prefix;

   assign req_tready = !cmd_full;
   assign cmd_push   = req_tvalid && !cmd_full;
   assign lookup     = b58_lookup(req_tdata);
   assign in_prefix  = (pos_ff < 4'(PREFIX_LEN));

   // classify one word
   always_comb begin
      pos_in        = pos_ff;
      run_in        = run_ff;
      ferr_in       = ferr_ff;
      cmd.kind      = CMD_SKIP;
      cmd.value     = lookup[5:0];
      cmd.err       = STATUS_FORMAT;
      cmd.last      = req_tlast;
      cmd.short_str = in_prefix;
      if (in_prefix) begin
         pos_in = pos_ff + 4'd1;
         if (!ferr_ff && req_tdata != prefix_char(pos_ff)) begin
            cmd.kind = CMD_ERR;
            ferr_in  = 1'b1;
         end
      end else if (!ferr_ff) begin
         if (run_ff && req_tdata == CHAR_ONE) begin
            cmd.kind = CMD_ONE;
         end else begin
            run_in = 1'b0;
            if (lookup[6]) begin
               cmd.kind = CMD_DIGIT;
            end else begin
               cmd.kind = CMD_ERR;
               cmd.err  = STATUS_DECODE;
               ferr_in  = 1'b1;
            end
         end
      end
      // a new string starts after the final character
      if (req_tlast) begin
         pos_in  = 4'd0;
         run_in  = 1'b1;
         ferr_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= 4'd0;
         run_ff  <= 1'b1;
         ferr_ff <= 1'b0;
      end else if (cmd_push) begin
         pos_ff  <= pos_in;
         run_ff  <= run_in;
         ferr_ff <= ferr_in;
      end
   end

endmodule

@@ sv/b58dec_back.sv @@
// b58dec_back: runs the multiply-by-58 carry passes over the digit store, does the final
// length and multicodec checks and streams out the key bytes or one error word.
// Depends on b58dec_pkg and b58dec_ram.
module b58dec_back #(
   parameter int DIGIT_DEPTH = b58dec_pkg::DIGIT_DEPTH_DEF,
   parameter int KEY_BYTES   = b58dec_pkg::KEY_BYTES_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  b58dec_pkg::cmd_type cmd,
   input  logic                cmd_empty,
   output logic                cmd_pop,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [7:0]          rsp_tdata,  // [7:0] key_byte
   output logic                rsp_tlast,  // last_byte
   output logic [1:0]          rsp_tuser   // [1:0] status
);
   import b58dec_pkg::*;

   localparam int AW = $clog2(DIGIT_DEPTH);
   localparam int CW = $clog2(DIGIT_DEPTH + 1);
   localparam int SW = ((CW > 7) ? CW : 7) + 1;
   localparam int MW = 14;

   bk_state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [6:0]    ones_ff, ones_in;
   logic          err_ff, err_in;
   status_type    kind_ff, kind_in;
   logic          last_ff, last_in;
   logic          short_ff, short_in;
   logic [5:0]    carry_ff, carry_in;
   logic [CW-1:0] rd_idx_ff, rd_idx_in;
   logic [AW-1:0] wr_idx_ff, wr_idx_in;
   logic          pend_ff, pend_in;
   logic          b0_ok_ff, b0_ok_in;
   logic [AW-1:0] out_idx_ff, out_idx_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [7:0]    rsp_data_ff, rsp_data_in;
   logic          rsp_last_ff, rsp_last_in;
   status_type    rsp_status_ff, rsp_status_in;
   logic          rsp_load;

   logic          ram_we, ram_re;
   logic [AW-1:0] ram_waddr, ram_raddr;
   logic [7:0]    ram_wdata, ram_rdata;

   logic [MW-1:0] mac;
   logic [SW-1:0] total;
   logic [CW-1:0] top_idx;
   logic          out_free;

   b58dec_ram #(
      .WIDTH (8),
      .DEPTH (DIGIT_DEPTH)
   ) u_digits (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // digit * 58 + carry, carry stays below 58
   assign mac      = MW'(carry_ff) + MW'(ram_rdata) * MW'(B58_RADIX);
   assign total    = SW'(ones_ff) + SW'(count_ff);
   assign top_idx  = count_ff - CW'(1);
   assign out_free = !rsp_valid_ff || rsp_tready;

   // sequencer
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      ones_in       = ones_ff;
      err_in        = err_ff;
      kind_in       = kind_ff;
      last_in       = last_ff;
      short_in      = short_ff;
      carry_in      = carry_ff;
      rd_idx_in     = rd_idx_ff;
      wr_idx_in     = wr_idx_ff;
      pend_in       = 1'b0;
      b0_ok_in      = b0_ok_ff;
      out_idx_in    = out_idx_ff;
      cmd_pop       = 1'b0;
      ram_we        = 1'b0;
      ram_waddr     = wr_idx_ff;
      ram_wdata     = mac[7:0];
      ram_re        = 1'b0;
      ram_raddr     = rd_idx_ff[AW-1:0];
      rsp_load      = 1'b0;
      rsp_data_in   = 8'd0;
      rsp_last_in   = 1'b1;
      rsp_status_in = kind_ff;

      unique case (state_ff)
         BK_IDLE: begin
            if (!cmd_empty) begin
               cmd_pop  = 1'b1;
               last_in  = cmd.last;
               short_in = cmd.short_str;
               state_in = cmd.last ? BK_FIN : BK_IDLE;
               if (!err_ff) begin
                  unique case (cmd.kind)
                     CMD_SKIP: ;
                     CMD_ONE: begin
                        if (ones_ff < ONES_MAX) begin
                           ones_in = ones_ff + 7'd1;
                        end
                     end
                     CMD_DIGIT: begin
                        carry_in  = cmd.value;
                        rd_idx_in = '0;
                        wr_idx_in = '0;
                        state_in  = BK_PASS;
                     end
                     CMD_ERR: begin
                        err_in  = 1'b1;
                        kind_in = cmd.err;
                     end
                     default: ;
                  endcase
               end
            end
         end

         // read digit j while writing back digit j-1
         BK_PASS: begin
            if (rd_idx_ff < count_ff) begin
               ram_re    = 1'b1;
               rd_idx_in = rd_idx_ff + CW'(1);
               pend_in   = 1'b1;
            end
            if (pend_ff) begin
               ram_we    = 1'b1;
               carry_in  = mac[13:8];
               wr_idx_in = wr_idx_ff + AW'(1);
            end
            if (!(rd_idx_ff < count_ff) && !pend_ff) begin
               if (carry_ff != 6'd0) begin
                  if (count_ff == CW'(DIGIT_DEPTH)) begin
                     err_in  = 1'b1;
                     kind_in = STATUS_SIZE;
                  end else begin
                     ram_we    = 1'b1;
                     ram_waddr = count_ff[AW-1:0];
                     ram_wdata = {2'b00, carry_ff};
                     count_in  = count_ff + CW'(1);
                  end
               end
               state_in = last_ff ? BK_FIN : BK_IDLE;
            end
         end

         // end-of-string checks, first error wins
         BK_FIN: begin
            priority if (err_ff) begin
               state_in = BK_ERR_OUT;
            end else if (short_ff) begin
               err_in   = 1'b1;
               kind_in  = STATUS_FORMAT;
               state_in = BK_ERR_OUT;
            end else if (total > SW'(DIGIT_DEPTH)) begin
               err_in   = 1'b1;
               kind_in  = STATUS_SIZE;
               state_in = BK_ERR_OUT;
            end else if (total != SW'(KEY_BYTES + 2) || ones_ff != 7'd0) begin
               err_in   = 1'b1;
               kind_in  = STATUS_FORMAT;
               state_in = BK_ERR_OUT;
            end else begin
               ram_re    = 1'b1;
               ram_raddr = top_idx[AW-1:0];
               state_in  = BK_CHK1;
            end
         end

         // multicodec byte 0 arrives, fetch byte 1
         BK_CHK1: begin
            b0_ok_in  = (ram_rdata == MULTICODEC_0);
            ram_re    = 1'b1;
            ram_raddr = top_idx[AW-1:0] - AW'(1);
            state_in  = BK_CHK2;
         end

         BK_CHK2: begin
            if (!b0_ok_ff || ram_rdata != MULTICODEC_1) begin
               err_in   = 1'b1;
               kind_in  = STATUS_FORMAT;
               state_in = BK_ERR_OUT;
            end else begin
               out_idx_in = AW'(KEY_BYTES - 1);
               state_in   = BK_OUT_RD;
            end
         end

         BK_ERR_OUT: begin
            if (out_free) begin
               rsp_load = 1'b1;
               count_in = '0;
               ones_in  = 7'd0;
               err_in   = 1'b0;
               kind_in  = STATUS_OK;
               state_in = BK_IDLE;
            end
         end

         BK_OUT_RD: begin
            if (out_free) begin
               ram_re    = 1'b1;
               ram_raddr = out_idx_ff;
               state_in  = BK_OUT_LD;
            end
         end

         // output register is free here: it was free when the read was issued
         BK_OUT_LD: begin
            rsp_load      = 1'b1;
            rsp_data_in   = ram_rdata;
            rsp_last_in   = (out_idx_ff == '0);
            rsp_status_in = STATUS_OK;
            if (out_idx_ff == '0) begin
               count_in = '0;
               ones_in  = 7'd0;
               err_in   = 1'b0;
               kind_in  = STATUS_OK;
               state_in = BK_IDLE;
            end else begin
               out_idx_in = out_idx_ff - AW'(1);
               state_in   = BK_OUT_RD;
            end
         end

         default: state_in = BK_IDLE;
      endcase
   end

   // output register valid
   always_comb begin
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         count_ff     <= '0;
         ones_ff      <= 7'd0;
         err_ff       <= 1'b0;
         kind_ff      <= STATUS_OK;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ones_ff      <= ones_in;
         err_ff       <= err_in;
         kind_ff      <= kind_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // working registers and output payload
   always_ff @(posedge clock) begin
      last_ff    <= last_in;
      short_ff   <= short_in;
      carry_ff   <= carry_in;
      rd_idx_ff  <= rd_idx_in;
      wr_idx_ff  <= wr_idx_in;
      b0_ok_ff   <= b0_ok_in;
      out_idx_ff <= out_idx_in;
      if (rsp_load) begin
         rsp_data_ff   <= rsp_data_in;
         rsp_last_ff   <= rsp_last_in;
         rsp_status_ff <= rsp_status_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_status_ff;

endmodule

@@ sv/did_key_base58_decoder.sv @@
// did_key_base58_decoder: top level of the did:key base58btc decoder.
// Depends on b58dec_pkg, b58dec_front, b58dec_fifo, b58dec_back (and b58dec_ram below it).
//
//   Channel   Direction  Ports                      Contents
//   req_      in         tvalid tready tdata tlast  one character, tlast on the final one
//   rsp_      out        tvalid tready tdata tlast  key byte, tlast on the final word,
//                        tuser                      tuser = status
//
// A prefix or leading '1' character is taken by the back end in its idle state; a base58
// character runs a carry pass over the stored digits through the single read and write
// port of the digit store. The final character adds the checks (BK_FIN, BK_CHK1, BK_CHK2),
// then a read and a load state per key byte; an error word is loaded in BK_ERR_OUT. The
// front end takes a word each cycle while the command queue has room, so the two sides
// stall independently. Reset is synchronous; no clearing pass.
module did_key_base58_decoder #(
   parameter int DIGIT_DEPTH = b58dec_pkg::DIGIT_DEPTH_DEF,
   parameter int KEY_BYTES   = b58dec_pkg::KEY_BYTES_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,  // [7:0] char_code
   input  logic       req_tlast,  // is_final
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,  // [7:0] key_byte
   output logic       rsp_tlast,  // last_byte
   output logic [1:0] rsp_tuser   // [1:0] status
);
   import b58dec_pkg::*;

   cmd_type push_cmd, pop_cmd;
   logic    push, pop, full, empty;

   // character classification
   b58dec_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .cmd_push   (push),
      .cmd        (push_cmd),
      .cmd_full   (full)
   );

   // command queue
   b58dec_fifo u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .full     (full),
      .pop      (pop),
      .pop_cmd  (pop_cmd),
      .empty    (empty)
   );

   // decoding and result stream
   b58dec_back #(
      .DIGIT_DEPTH (DIGIT_DEPTH),
      .KEY_BYTES   (KEY_BYTES)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd        (pop_cmd),
      .cmd_empty  (empty),
      .cmd_pop    (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

@@ tb/tb_did_key_base58_decoder.sv @@
// Testbench for did_key_base58_decoder: streams did:key strings in, checks every key byte
// or error word out against a cycle-free decoder model kept in this file.
// Depends on b58dec_pkg and the decoder RTL only.
`timescale 1ns / 100ps

module tb_did_key_base58_decoder;
   import b58dec_pkg::*;

   localparam int    DIGIT_DEPTH  = DIGIT_DEPTH_DEF;
   localparam int    KEY_BYTES    = KEY_BYTES_DEF;
   localparam int    CYCLE_LIMIT  = 1_000_000;
   localparam int    DRAIN_CYCLES = 100;
   localparam int    MAX_REPORTS  = 10;
   localparam int    RANDOM_CHARS = 250;   // stop the random part past this many characters
   localparam int    QUIET_CHARS  = 200;   // no idling on either side past this point
   localparam string PREFIX_TEXT  = "did:key:z";
   localparam string ALPHABET     =
      "123456789ABCDEFGHJKLMNPQRSTUVWXYZabcdefghijkmnopqrstuvwxyz";

   typedef logic [7:0] char_q_type[$];

   typedef struct packed {
      logic [7:0] key_byte;
      logic       last_byte;
      status_type status;
   } key_word_type;

   logic       clock      = 1'b0;
   logic       reset      = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata  = 8'h00;
   logic       req_tlast  = 1'b0;
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;
   logic       rsp_tlast;
   logic [1:0] rsp_tuser;

   bit          idling_on  = 1'b1;
   int unsigned fail_count = 0;
   int unsigned chars_sent = 0;
   int unsigned cycles     = 0;
   int          tready_hold = 0;

   key_word_type key_words_q[$];   // key bytes / error words still to come out

   // decoder model state
   logic [7:0]  dec_digits [DIGIT_DEPTH];   // base-256 digits, least significant first
   int unsigned dec_count;
   int unsigned dec_ones;
   int unsigned dec_pos;
   bit          dec_in_ones;
   bit          dec_failed;
   status_type  dec_status;

   did_key_base58_decoder #(
      .DIGIT_DEPTH (DIGIT_DEPTH),
      .KEY_BYTES   (KEY_BYTES)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   // 10 ns clock
   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // ---------------------------------------------------------------- decoder model

   function automatic int b58_digit(logic [7:0] c);
      for (int v = 0; v < 58; v++)
         if (ALPHABET[v] == c) return v;
      return -1;
   endfunction

   // only the first error of a string counts
   function automatic void set_error(status_type kind);
      if (!dec_failed) begin
         dec_failed = 1'b1;
         dec_status = kind;
      end
   endfunction

   function automatic void clear_string();
      dec_count   = 0;
      dec_ones    = 0;
      dec_pos     = 0;
      dec_in_ones = 1'b1;
      dec_failed  = 1'b0;
      dec_status  = STATUS_OK;
   endfunction

   // byte i of the big-endian decoded value: leading zeros, then the digits
   function automatic logic [7:0] decoded_at(int unsigned i);
      int unsigned k;
      if (i < dec_ones) return 8'h00;
      k = i - dec_ones;
      if (k >= dec_count || dec_count > DIGIT_DEPTH) return 8'h00;
      return dec_digits[dec_count - 1 - k];
   endfunction

   // one base58 character: count leading ones, else value = value * 58 + digit
   function automatic void add_base58(logic [7:0] c);
      int          v;
      int unsigned carry;
      if (dec_in_ones && c == CHAR_ONE) begin
         if (dec_ones < ONES_MAX) dec_ones++;
         return;
      end
      dec_in_ones = 1'b0;
      v = b58_digit(c);
      if (v < 0) begin
         set_error(STATUS_DECODE);
         return;
      end
      carry = v;
      for (int j = 0; j < dec_count; j++) begin
         carry = carry + 32'(dec_digits[j]) * 32'd58;
         dec_digits[j] = carry[7:0];
         carry = carry >> 8;
      end
      while (carry > 0) begin
         if (dec_count >= DIGIT_DEPTH) begin
            set_error(STATUS_SIZE);
            return;
         end
         dec_digits[dec_count] = carry[7:0];
         carry = carry >> 8;
         dec_count++;
      end
   endfunction

   // advance the model by one accepted character; queue the words it produces
   function automatic void decode_char(logic [7:0] c, bit fin);
      bit           short_str;
      key_word_type w;
      short_str = dec_pos < PREFIX_LEN;
      if (!dec_failed) begin
         if (dec_pos < PREFIX_LEN) begin
            if (c != PREFIX_TEXT[dec_pos]) set_error(STATUS_FORMAT);
         end else begin
            add_base58(c);
         end
      end
      if (dec_pos < PREFIX_LEN) dec_pos++;
      if (!fin) return;

      // end-of-string checks, in priority order
      if (short_str) set_error(STATUS_FORMAT);
      if (!dec_failed && dec_ones + dec_count > DIGIT_DEPTH) set_error(STATUS_SIZE);
      if (!dec_failed && dec_ones + dec_count != KEY_BYTES + 2) set_error(STATUS_FORMAT);
      if (!dec_failed && (decoded_at(0) != MULTICODEC_0 || decoded_at(1) != MULTICODEC_1))
         set_error(STATUS_FORMAT);

      if (dec_failed) begin
         w.key_byte  = 8'h00;
         w.last_byte = 1'b1;
         w.status    = dec_status;
         key_words_q.push_back(w);
      end else begin
         for (int i = 0; i < KEY_BYTES; i++) begin
            w.key_byte  = decoded_at(i + 2);
            w.last_byte = (i == KEY_BYTES - 1);
            w.status    = STATUS_OK;
            key_words_q.push_back(w);
         end
      end
      clear_string();
   endfunction

   // ---------------------------------------------------------------- string builders

   function automatic char_q_type prefix_chars();
      char_q_type s;
      for (int i = 0; i < PREFIX_TEXT.len(); i++) s.push_back(PREFIX_TEXT[i]);
      return s;
   endfunction

   // did:key:z followed by the base58 form of payload (zero bytes lead as '1')
   function automatic char_q_type did_string(char_q_type payload);
      char_q_type  s;
      int unsigned digs[$];
      int unsigned carry;
      int          zeros;
      s = prefix_chars();
      zeros = 0;
      while (zeros < payload.size() && payload[zeros] == 8'h00) zeros++;
      foreach (payload[i]) begin
         carry = payload[i];
         foreach (digs[j]) begin
            carry   = carry + digs[j] * 256;
            digs[j] = carry % 58;
            carry   = carry / 58;
         end
         while (carry > 0) begin
            digs.push_back(carry % 58);
            carry = carry / 58;
         end
      end
      repeat (zeros) s.push_back(CHAR_ONE);
      for (int j = digs.size() - 1; j >= 0; j--) s.push_back(ALPHABET[digs[j]]);
      return s;
   endfunction

   function automatic char_q_type rand_bytes(int n);
      char_q_type q;
      repeat (n) q.push_back(8'($urandom));
      return q;
   endfunction

   // n zero bytes ahead of tail
   function automatic char_q_type with_zeros(int n, char_q_type tail);
      char_q_type q;
      repeat (n) q.push_back(8'h00);
      foreach (tail[i]) q.push_back(tail[i]);
      return q;
   endfunction

   // multicodec header plus a key; fill < 0 gives random key bytes
   function automatic char_q_type key_payload(int fill);
      char_q_type q;
      q = '{MULTICODEC_0, MULTICODEC_1};
      repeat (KEY_BYTES) q.push_back(fill < 0 ? 8'($urandom) : 8'(fill));
      return q;
   endfunction

   // ---------------------------------------------------------------- driving

   task automatic send_char(logic [7:0] c, bit fin);
      if (idling_on && $urandom_range(0, 7) == 0)
         repeat ($urandom_range(1, 8)) begin
            @(negedge clock);
            req_tvalid <= 1'b0;
         end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      req_tlast  <= fin;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      decode_char(c, fin);
      chars_sent++;
   endtask

   task automatic send_string(char_q_type s);
      foreach (s[i]) send_char(s[i], i == s.size() - 1);
   endtask

   // result side: random stall bursts on rsp_tready
   always @(negedge clock) begin
      if (tready_hold > 0) begin
         tready_hold--;
         rsp_tready <= 1'b0;
      end else if (idling_on && $urandom_range(0, 7) == 0) begin
         tready_hold = $urandom_range(0, 7);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // ---------------------------------------------------------------- checking

   always @(posedge clock) begin
      key_word_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (key_words_q.size() == 0) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
               $display("%0t: unexpected word: key_byte %h last %b status %0d",
                        $realtime, rsp_tdata, rsp_tlast, rsp_tuser);
         end else begin
            want = key_words_q.pop_front();
            if (rsp_tdata !== want.key_byte || rsp_tlast !== want.last_byte ||
                rsp_tuser !== want.status) begin
               fail_count++;
               if (fail_count <= MAX_REPORTS)
                  $display("%0t: mismatch: expected key_byte %h last %b status %0d, got %h %b %0d",
                           $realtime, want.key_byte, want.last_byte, want.status,
                           rsp_tdata, rsp_tlast, rsp_tuser);
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb_did_key_base58_decoder: done, errors");
         $finish;
      end
   end

   // ---------------------------------------------------------------- tests

   task automatic check_valid_keys();
      send_string(did_string(key_payload(-1)));
   endtask

   // strings that end inside the prefix
   task automatic check_short_strings();
      char_q_type s;
      s = prefix_chars();
      send_string(s[0:0]);
      send_string(s);
   endtask

   task automatic check_prefix_errors();
      char_q_type s;
      s = prefix_chars();
      s.push_back("2");
      s[0] = "D";
      send_string(s);
      s = prefix_chars();
      s.push_back("2");
      s[8] = "Z";
      send_string(s);
   endtask

   // characters outside the alphabet, including NUL and a high code
   task automatic check_bad_characters();
      logic [7:0] bad [3] = '{"0", 8'h00, 8'hff};
      char_q_type s;
      foreach (bad[k]) begin
         s = prefix_chars();
         s.push_back("2");
         s.push_back(bad[k]);
         s.push_back("3");
         send_string(s);
      end
   endtask

   // a leading '1' ahead of the digits, wrong length
   task automatic check_leading_ones();
      char_q_type z;
      z = '{MULTICODEC_0, MULTICODEC_1};
      send_string(did_string(with_zeros(1, z)));
   endtask

   // digit store runs out during the carry pass
   task automatic check_size_limits();
      char_q_type s;
      s = prefix_chars();
      repeat (90) s.push_back("z");
      send_string(s);
   endtask

   task automatic check_length_and_codec();
      char_q_type s;
      s = '{MULTICODEC_0, MULTICODEC_1, 8'h5a};
      send_string(did_string(s));
   endtask

   // mostly well-formed keys, the rest broken in the ways above
   task automatic check_random_strings();
      char_q_type s;
      char_q_type z;
      int         kind;
      int         n;
      while (chars_sent < RANDOM_CHARS) begin
         if (chars_sent >= QUIET_CHARS) idling_on = 1'b0;
         kind = $urandom_range(0, 19);
         if (kind <= 10) begin
            s = did_string(key_payload(-1));
         end else if (kind <= 12) begin
            s = did_string(key_payload(-1));
            s[$urandom_range(PREFIX_LEN, s.size() - 1)] = 8'($urandom_range(0, 255));
         end else if (kind <= 14) begin
            s = rand_bytes($urandom_range(1, 40));
            if ($urandom_range(0, 1) && s.size() >= 2) begin
               s[0] = MULTICODEC_0;
               s[1] = MULTICODEC_1;
            end
            if (s[0] == 8'h00) s[0] = 8'h01;
            s = did_string(s);
         end else if (kind == 15) begin
            s = did_string(key_payload(-1));
            s[$urandom_range(0, PREFIX_LEN - 1)] = 8'($urandom_range(0, 255));
         end else if (kind == 16) begin
            s = prefix_chars();
            n = $urandom_range(1, PREFIX_LEN);
            s = s[0:n - 1];
            if ($urandom_range(0, 1)) s[n - 1] = 8'($urandom_range(0, 255));
         end else if (kind == 17) begin
            z = key_payload(-1);
            s = did_string(with_zeros($urandom_range(1, 70), z));
         end else if (kind == 18) begin
            s = prefix_chars();
            repeat ($urandom_range(1, 90)) s.push_back(ALPHABET[$urandom_range(0, 57)]);
         end else begin
            s = prefix_chars();
            repeat ($urandom_range(1, 60)) s.push_back(8'($urandom_range(0, 255)));
         end
         send_string(s);
      end
   endtask

   // ---------------------------------------------------------------- sequence

   initial begin
      clear_string();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      check_valid_keys();
      check_short_strings();
      check_prefix_errors();
      check_bad_characters();
      check_leading_ones();
      check_size_limits();
      check_length_and_codec();
      check_random_strings();

      @(negedge clock);
      req_tvalid <= 1'b0;
      while (key_words_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0)
         $display("tb_did_key_base58_decoder: done, clean");
      else
         $display("tb_did_key_base58_decoder: done, errors");
      $finish;
   end

endmodule
